@@ rtl/prt_pkg.sv @@
package prt_pkg;

	typedef enum logic [3:0] {
		ACT_ADD       = 4'd0,
		ACT_REMOVE    = 4'd1,
		ACT_EXISTS    = 4'd2,
		ACT_COMPLETE  = 4'd3,
		ACT_FAIL      = 4'd4,
		ACT_SWEEP     = 4'd5,
		ACT_FAIL_CONN = 4'd6,
		ACT_FAIL_ALL  = 4'd7,
		ACT_FAIL_FROM = 4'd8
	} action_t;

	localparam int ENTRY_W = 64 + 64 + 64 + 16 + 64;

	// one stored slot, index in the lowest bits
	typedef struct packed {
		logic [63:0] request;
		logic [15:0] conn;
		logic [63:0] deadline;
		logic [63:0] term;
		logic [63:0] index;
	} entry_t;

	// one result word
	typedef struct packed {
		logic        last;
		logic [6:0]  occupancy;
		logic [6:0]  swept_count;
		logic [7:0]  notice_error;
		entry_t      entry;
		logic        ok;
		logic        kind;
	} result_t;

endpackage

@@ rtl/prt_ram.sv @@
module prt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/pending_request_table.sv @@
// Pending request table.
// Input words arrive on s_axis (tdata holds the request fields, action in the
// lowest bits); results leave on m_axis, tuser carrying kind and tlast marking
// the final result of each input word. The user writes timeout_code via
// cfg_we/cfg_wdata only while idle; the block does not enforce this.
// Slot contents live in one RAM with a registered read; valid bits
// sit in flip-flops. The block handles one input word at a time, reading a
// slot in ST_READ and examining it in ST_EXAM, for each slot a scan visits.
// An add or an unknown action loads its result into the output register
// from ST_ADD or ST_REPLY, then returns to idle, so a new add is taken only
// after the last result is loaded. An add never scans: the lowest free
// slot comes from the valid bits. Lookups stop at the first match or after
// the last slot. Sweeps always scan every slot, emitting one notice word
// per cleared slot, then the count. When the receiver stalls the scan
// waits on the one-word output register; a new input is taken only once
// idle and that register can take a word. Reset clears all valid bits,
// the occupancy count and sets timeout_code to -1; the RAM itself needs
// no clearing.
module pending_request_table
	import prt_pkg::*;
#(
	parameter int SLOTS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// action[3:0], index_key[67:4], term[131:68], deadline[195:132],
	// conn_id[211:196], req_tag[275:212], error_code[283:276],
	// now_time[347:284], zero fill to 351
	input  logic [351:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// ok[0], entry_index[64:1], entry_term[128:65], entry_deadline[192:129],
	// entry_conn[208:193], entry_request[272:209], notice_error[280:273],
	// swept_count[287:281], occupancy[294:288], zero fill to 295
	output logic [295:0] m_axis_tdata,
	output logic         m_axis_tuser,   // kind
	output logic         m_axis_tlast,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_EXAM, ST_REPLY, ST_ADD} state_t;

	state_t          state_q;
	logic [3:0]      act_q;
	logic [63:0]     key_q, term_q, dl_q, req_q, now_q;
	logic [15:0]     conn_q;
	logic [7:0]      err_q, tcode_q;
	logic [AW-1:0]   ptr_q;
	logic [SLOTS-1:0] valid_q;
	logic [CW-1:0]   used_q, swept_q;
	logic            found_q;
	logic            obuf_v_q;
	result_t         obuf_q;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	entry_t          ram_wdata, ram_rdata;

	prt_ram #(.WIDTH(ENTRY_W), .DEPTH(1 << AW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	// lowest free slot
	logic [AW-1:0] free_slot;
	logic          has_free;
	always_comb begin
		free_slot = '0;
		has_free  = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot = AW'(i);
				has_free  = 1'b1;
			end
		end
	end

	// match test on the slot read last cycle
	logic hit;
	logic is_sweep;
	always_comb begin
		is_sweep = (act_q == ACT_SWEEP) || (act_q == ACT_FAIL_CONN) ||
			(act_q == ACT_FAIL_ALL) || (act_q == ACT_FAIL_FROM);
		case (act_q)
			ACT_REMOVE, ACT_EXISTS, ACT_COMPLETE, ACT_FAIL:
				hit = ram_rdata.index == key_q;
			ACT_SWEEP:     hit = ram_rdata.deadline <= now_q;
			ACT_FAIL_CONN: hit = (conn_q != '0) && (ram_rdata.conn == conn_q);
			ACT_FAIL_ALL:  hit = 1'b1;
			ACT_FAIL_FROM: hit = ram_rdata.index >= key_q;
			default:       hit = 1'b0;
		endcase
		hit = hit && valid_q[ptr_q] && !found_q;
		if (is_sweep) begin
			hit = hit || 1'b0;
		end
	end

	logic out_free;
	logic add_ok;
	assign out_free      = !obuf_v_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && out_free;
	assign add_ok        = has_free && (conn_q != '0);

	assign ram_we    = (state_q == ST_ADD) && add_ok;
	assign ram_waddr = free_slot;
	assign ram_wdata = '{request: req_q, conn: conn_q, deadline: dl_q,
		term: term_q, index: key_q};

	// next result word and when it is loaded
	logic    out_load;
	result_t out_word;
	always_comb begin
		out_load = 1'b0;
		out_word = '0;
		case (state_q)
			ST_ADD: begin
				out_load           = out_free;
				out_word.last      = 1'b1;
				out_word.ok        = add_ok;
				out_word.occupancy = add_ok ? 7'(used_q + 1'b1) : 7'(used_q);
			end
			ST_EXAM: begin
				out_load       = out_free && hit && (act_q != ACT_EXISTS);
				out_word.kind  = (act_q != ACT_REMOVE);
				out_word.ok    = 1'b1;
				out_word.entry = ram_rdata;
				out_word.last  = (act_q == ACT_REMOVE);
				out_word.notice_error = (act_q == ACT_SWEEP) ? tcode_q :
					(act_q == ACT_COMPLETE || act_q == ACT_REMOVE) ? 8'd0 : err_q;
				out_word.occupancy = 7'(used_q - 1'b1);
			end
			ST_REPLY: begin
				out_load           = out_free;
				out_word.last      = 1'b1;
				out_word.occupancy = 7'(used_q);
				if (is_sweep) begin
					out_word.ok = !(act_q == ACT_FAIL_CONN && conn_q == '0);
					out_word.swept_count = 7'(swept_q);
				end else begin
					out_word.ok = found_q;
				end
			end
			default: out_load = 1'b0;
		endcase
	end

	// control, scan and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_q  <= '0;
			used_q   <= '0;
			obuf_v_q <= 1'b0;
			obuf_q   <= '0;
			tcode_q  <= 8'hFF;
			ptr_q    <= '0;
			found_q  <= 1'b0;
			swept_q  <= '0;
			act_q    <= '0;
		end else begin
			if (cfg_we) begin
				tcode_q <= cfg_wdata;
			end
			if (out_load) begin
				obuf_v_q <= 1'b1;
				obuf_q   <= out_word;
			end else if (m_axis_tready) begin
				obuf_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && out_free) begin
						act_q   <= s_axis_tdata[3:0];
						key_q   <= s_axis_tdata[67:4];
						term_q  <= s_axis_tdata[131:68];
						dl_q    <= s_axis_tdata[195:132];
						conn_q  <= s_axis_tdata[211:196];
						req_q   <= s_axis_tdata[275:212];
						err_q   <= s_axis_tdata[283:276];
						now_q   <= s_axis_tdata[347:284];
						ptr_q   <= '0;
						found_q <= 1'b0;
						swept_q <= '0;
						case (s_axis_tdata[3:0])
							ACT_ADD: state_q <= ST_ADD;
							ACT_REMOVE, ACT_EXISTS, ACT_COMPLETE, ACT_FAIL,
							ACT_SWEEP, ACT_FAIL_CONN, ACT_FAIL_ALL, ACT_FAIL_FROM:
								state_q <= ST_READ;
							default: state_q <= ST_REPLY;
						endcase
					end
				end
				ST_ADD: begin
					// slot write happens while add_ok holds; valid bit and reply load wait on out_free
					if (out_free) begin
						if (add_ok) begin
							valid_q[free_slot] <= 1'b1;
							used_q             <= used_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					state_q <= ST_EXAM;
				end
				ST_EXAM: begin
					if (hit && act_q != ACT_EXISTS) begin
						if (out_free) begin
							used_q  <= used_q - 1'b1;
							valid_q[ptr_q] <= 1'b0;
							swept_q <= swept_q + 1'b1;
							if (!is_sweep) begin
								found_q <= 1'b1;
							end
							if (act_q == ACT_REMOVE) begin
								state_q <= ST_IDLE;
							end else if (!is_sweep || int'(ptr_q) == SLOTS - 1) begin
								state_q <= ST_REPLY;
							end else begin
								ptr_q   <= ptr_q + 1'b1;
								state_q <= ST_READ;
							end
						end
					end else begin
						if (hit) begin
							found_q <= 1'b1;
						end
						if (hit || int'(ptr_q) == SLOTS - 1) begin
							state_q <= ST_REPLY;
						end else begin
							ptr_q   <= ptr_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				ST_REPLY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = obuf_v_q;
	assign m_axis_tuser  = obuf_q.kind;
	assign m_axis_tlast  = obuf_q.last;
	assign m_axis_tdata  = {1'b0, obuf_q.occupancy, obuf_q.swept_count,
		obuf_q.notice_error, obuf_q.entry, obuf_q.ok};

	// occupancy never exceeds the table
	assert property (@(posedge clk) disable iff (!arst_n) int'(used_q) <= SLOTS)
		else $error("occupancy above table size");
	// occupancy tracks the valid bits
	assert property (@(posedge clk) disable iff (!arst_n)
		int'(used_q) == $countones(valid_q))
		else $error("occupancy differs from valid bits");
	// no input taken while a scan is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXAM) |-> !s_axis_tready)
		else $error("input accepted during scan");

endmodule
